// ===== src/sdm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register map for the sigma-delta modulator.
// No dependencies; every other file of the block imports this package.
package sdm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int WORD_BITS = 16;
    localparam int BIT_IDX_W = $clog2(WORD_BITS);
    localparam int COEF_W    = 21;
    localparam int WPS_W     = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 5;
    localparam int REG_IDX_W = 3;

    localparam int MAX_WORDS_DEF = 12;
    localparam int FRAC_BITS_DEF = 20;
    localparam int ACC_WIDTH_DEF = 40;

    typedef logic [COEF_W-1:0]    coef_t;
    typedef logic [WPS_W-1:0]     wps_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [1:0]           fb_t;

    // register indexes (byte address = 4 * index)
    localparam reg_idx_t REG_COEF_INPUT    = 3'd0;
    localparam reg_idx_t REG_COEF_SECOND   = 3'd1;
    localparam reg_idx_t REG_COEF_THIRD    = 3'd2;
    localparam reg_idx_t REG_RESONATOR     = 3'd3;
    localparam reg_idx_t REG_WORDS         = 3'd4;

    localparam coef_t RST_COEF_INPUT  = 21'd121425;
    localparam coef_t RST_COEF_SECOND = 21'd291085;
    localparam coef_t RST_COEF_THIRD  = 21'd1076573;
    localparam coef_t RST_RESONATOR   = 21'd1613;
    localparam wps_t  RST_WORDS       = 4'd3;

    // feedback level codes: two's complement of 0, +1, -1
    localparam fb_t FB_ZERO = 2'b00;
    localparam fb_t FB_POS  = 2'b01;
    localparam fb_t FB_NEG  = 2'b11;

    typedef struct packed {
        coef_t k1;
        coef_t k2;
        coef_t k3;
        coef_t g;
    } coef_set_t;

endpackage

// ===== src/sdm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts PCM samples, scales them to the integrator format and
// resolves the word count. Depends on sdm_pkg.
module sdm_front #(
    parameter int MAX_WORDS = sdm_pkg::MAX_WORDS_DEF,
    parameter int FRAC_BITS = sdm_pkg::FRAC_BITS_DEF,
    parameter int WCNT_W    = $clog2(MAX_WORDS + 1)
) (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sdm_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] pcm_sample
    input  sdm_pkg::wps_t                words_per_sample,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic signed [FRAC_BITS-1:0]  push_u,
    output logic [WCNT_W-1:0]            push_words
);
    import sdm_pkg::*;

    logic signed [SAMPLE_W-1:0] sample;

    assign sample     = $signed(s_tdata);
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    // scale to FRAC_BITS fraction bits; narrower formats floor
    generate
        if (FRAC_BITS >= SAMPLE_W) begin : g_widen
            assign push_u = FRAC_BITS'(sample) <<< (FRAC_BITS - SAMPLE_W);
        end else begin : g_narrow
            logic signed [SAMPLE_W-1:0] shifted;
            assign shifted = sample >>> (SAMPLE_W - FRAC_BITS);
            assign push_u  = shifted[FRAC_BITS-1:0];
        end
    endgenerate

    // zero acts as one, anything above the limit acts as the limit
    always_comb
    begin
        if (words_per_sample == '0)
        begin
            push_words = WCNT_W'(1);
        end
        else if ({{WCNT_W{1'b0}}, words_per_sample} > (WCNT_W + WPS_W)'(MAX_WORDS))
        begin
            push_words = WCNT_W'(MAX_WORDS);
        end
        else
        begin
            push_words = WCNT_W'(words_per_sample);
        end
    end

endmodule

// ===== src/sdm_queue.sv =====
`timescale 1ns / 1ps
// Two-entry register queue between the front end and the modulator loop.
// Depends on sdm_pkg.
module sdm_queue #(
    parameter int WIDTH = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import sdm_pkg::*;

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != 2'(DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/sdm_loop.sv =====
`timescale 1ns / 1ps
// Modulator loop: three saturating integrators stepped phase by phase for each bit,
// word assembly and the output register. Depends on sdm_pkg.
module sdm_loop #(
    parameter int MAX_WORDS = sdm_pkg::MAX_WORDS_DEF,
    parameter int FRAC_BITS = sdm_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = sdm_pkg::ACC_WIDTH_DEF,
    parameter int WCNT_W    = $clog2(MAX_WORDS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdm_pkg::coef_set_t            coefs,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [FRAC_BITS-1:0]   in_u,
    input  logic [WCNT_W-1:0]             in_words,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sdm_pkg::WORD_BITS-1:0] out_word,
    output logic                          out_last,
    output logic                          out_sat
);
    import sdm_pkg::*;

    localparam int LO_W   = ACC_WIDTH / 2;
    localparam int HI_W   = ACC_WIDTH - LO_W;
    localparam int DIFF_W = FRAC_BITS + 2;
    localparam int K1P_W  = DIFF_W + COEF_W + 1;
    localparam int PLO_W  = LO_W + COEF_W;
    localparam int PHI_W  = HI_W + COEF_W + 1;
    localparam int PW     = ACC_WIDTH + COEF_W + 1;
    localparam int GS_W   = PW - FRAC_BITS;
    localparam int EXT    = ACC_WIDTH + 12;

    localparam logic signed [DIFF_W-1:0] ONE_Q = DIFF_W'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    localparam logic [1:0] PH_MLO = 2'd0;  // first-stage product, low resonator product
    localparam logic [1:0] PH_MHI = 2'd1;  // high resonator product, integrator one
    localparam logic [1:0] PH_S1  = 2'd2;  // integrator two
    localparam logic [1:0] PH_S2  = 2'd3;  // integrator three, bit decision

    // {clipped, value}
    function automatic logic [ACC_WIDTH:0] clamp(input logic signed [EXT-1:0] t);
        logic [EXT-ACC_WIDTH:0] top;
        top = t[EXT-1:ACC_WIDTH-1];
        if ((&top) || !(|top))
        begin
            return {1'b0, t[ACC_WIDTH-1:0]};
        end
        else if (t[EXT-1])
        begin
            return {1'b1, ACC_MIN};
        end
        else
        begin
            return {1'b1, ACC_MAX};
        end
    endfunction

    logic                        busy_reg, busy_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [BIT_IDX_W-1:0]        bit_reg, bit_next;
    logic [WCNT_W-1:0]           word_reg, word_next;
    logic [WCNT_W-1:0]           words_reg, words_next;
    logic signed [FRAC_BITS-1:0] u_reg, u_next;
    logic signed [ACC_WIDTH-1:0] s0_reg, s0_next;
    logic signed [ACC_WIDTH-1:0] s1_reg, s1_next;
    logic signed [ACC_WIDTH-1:0] s2_reg, s2_next;
    fb_t                         fb_reg, fb_next;
    logic signed [K1P_W-1:0]     k1p_reg, k1p_next;
    logic [PLO_W-1:0]            plo_reg, plo_next;
    logic signed [GS_W-1:0]      gs_reg, gs_next;
    logic [WORD_BITS-1:0]        bits_reg, bits_next;
    logic                        sat_reg, sat_next;
    logic                        out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]        out_word_reg, out_word_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_sat_reg, out_sat_next;

    logic signed [DIFF_W-1:0]    diff;
    logic signed [K1P_W-1:0]     k1p_prod;
    logic [PLO_W-1:0]            plo_prod;
    logic signed [PHI_W-1:0]     phi_prod;
    logic signed [PW-1:0]        gs_full;
    logic signed [EXT-1:0]       kv2, kv3, t0, t1, t2;
    logic [ACC_WIDTH:0]          c0, c1, c2;
    logic                        bit_pos, last_bit, stall;

    assign in_ready  = !busy_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_last  = out_last_reg;
    assign out_sat   = out_sat_reg;

    // datapath
    always_comb
    begin
        case (fb_reg)
            FB_POS:  diff = DIFF_W'(u_reg) - ONE_Q;
            FB_NEG:  diff = DIFF_W'(u_reg) + ONE_Q;
            default: diff = DIFF_W'(u_reg);
        endcase
        case (fb_reg)
            FB_POS:
            begin
                kv2 = EXT'($signed({1'b0, coefs.k2}));
                kv3 = EXT'($signed({1'b0, coefs.k3}));
            end
            FB_NEG:
            begin
                kv2 = -EXT'($signed({1'b0, coefs.k2}));
                kv3 = -EXT'($signed({1'b0, coefs.k3}));
            end
            default:
            begin
                kv2 = '0;
                kv3 = '0;
            end
        endcase
        k1p_prod = diff * $signed({1'b0, coefs.k1});
        plo_prod = s2_reg[LO_W-1:0] * coefs.g;
        phi_prod = $signed(s2_reg[ACC_WIDTH-1:LO_W]) * $signed({1'b0, coefs.g});
        gs_full  = (PW'(phi_prod) <<< LO_W) + $signed(PW'(plo_reg));
        t0 = EXT'(s0_reg) + EXT'($signed(k1p_reg[K1P_W-1:FRAC_BITS]));
        t1 = EXT'(s1_reg) + EXT'(s0_reg) - kv2 - EXT'(gs_reg);
        t2 = EXT'(s2_reg) + EXT'(s1_reg) - kv3;
        c0 = clamp(t0);
        c1 = clamp(t1);
        c2 = clamp(t2);
        bit_pos  = !c2[ACC_WIDTH-1] && (|c2[ACC_WIDTH-1:0]);
        last_bit = (bit_reg == BIT_IDX_W'(WORD_BITS - 1));
    end

    // hold the final step of a word while the output register is still full
    assign stall = busy_reg && (phase_reg == PH_S2) && last_bit && out_valid_reg && !out_ready;

    always_comb
    begin
        busy_next      = busy_reg;
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        word_next      = word_reg;
        words_next     = words_reg;
        u_next         = u_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        fb_next        = fb_reg;
        k1p_next       = k1p_reg;
        plo_next       = plo_reg;
        gs_next        = gs_reg;
        bits_next      = bits_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next  = 1'b1;
                phase_next = PH_MLO;
                bit_next   = '0;
                word_next  = '0;
                words_next = in_words;
                u_next     = in_u;
                bits_next  = '0;
                sat_next   = 1'b0;
            end
        end
        else if (!stall)
        begin
            case (phase_reg)
                PH_MLO:
                begin
                    k1p_next   = k1p_prod;
                    plo_next   = plo_prod;
                    phase_next = PH_MHI;
                end
                PH_MHI:
                begin
                    s0_next    = $signed(c0[ACC_WIDTH-1:0]);
                    sat_next   = sat_reg | c0[ACC_WIDTH];
                    gs_next    = gs_full[PW-1:FRAC_BITS];
                    phase_next = PH_S1;
                end
                PH_S1:
                begin
                    s1_next    = $signed(c1[ACC_WIDTH-1:0]);
                    sat_next   = sat_reg | c1[ACC_WIDTH];
                    phase_next = PH_S2;
                end
                PH_S2:
                begin
                    s2_next            = $signed(c2[ACC_WIDTH-1:0]);
                    sat_next           = sat_reg | c2[ACC_WIDTH];
                    fb_next            = bit_pos ? FB_POS : FB_NEG;
                    bits_next[bit_reg] = bit_pos;
                    bit_next           = bit_reg + 1'b1;
                    phase_next         = PH_MLO;
                    if (last_bit)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = bits_next;
                        out_last_next  = (word_reg + 1'b1 == words_reg);
                        out_sat_next   = sat_next;
                        bits_next      = '0;
                        sat_next       = 1'b0;
                        word_next      = word_reg + 1'b1;
                        if (word_reg + 1'b1 == words_reg)
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_MLO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_MLO;
            bit_reg       <= '0;
            word_reg      <= '0;
            words_reg     <= '0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            fb_reg        <= FB_ZERO;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            word_reg      <= word_next;
            words_reg     <= words_next;
            s0_reg        <= s0_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            fb_reg        <= fb_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        k1p_reg      <= k1p_next;
        plo_reg      <= plo_next;
        gs_reg       <= gs_next;
        bits_reg     <= bits_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
        out_sat_reg  <= out_sat_next;
    end

endmodule

// ===== src/third_order_sigma_delta_modulator.sv =====
`timescale 1ns / 1ps
// Third-order sigma-delta modulator: PCM samples in, 16-bit PDM words out.
// Each modulator bit runs through one step sequence that the loop shares: products,
// integrator one, integrator two, integrator three. The loop starts the next
// sample only after the last word of the current one.
// Up to two samples wait in the queue while the loop works.
// Reset (rst_n, async, active low) zeroes the integrators and feedback and
// restores the default coefficients; depends on sdm_pkg and the sdm_* modules.
module third_order_sigma_delta_modulator #(
    parameter int MAX_WORDS = sdm_pkg::MAX_WORDS_DEF,
    parameter int FRAC_BITS = sdm_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH = sdm_pkg::ACC_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sdm_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] pcm_sample
    // PDM word stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdm_pkg::WORD_BITS-1:0] m_tdata,   // [15:0] pdm_word
    output logic                          m_tlast,   // last_word
    output logic                          m_tuser,   // [0] saturated
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdm_pkg::APB_AW-1:0]    paddr,
    input  logic [sdm_pkg::APB_DW-1:0]    pwdata,
    output logic [sdm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import sdm_pkg::*;

    localparam int WCNT_W = $clog2(MAX_WORDS + 1);
    localparam int QW     = FRAC_BITS + WCNT_W;

    // configuration registers
    coef_t    coef_input_reg;
    coef_t    coef_second_reg;
    coef_t    coef_third_reg;
    coef_t    resonator_gain_reg;
    wps_t     words_per_sample_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;
    coef_set_t coefs;

    // front to queue
    logic                        push_valid, push_ready;
    logic signed [FRAC_BITS-1:0] push_u;
    logic [WCNT_W-1:0]           push_words;

    // queue to loop
    logic                        pop_valid, pop_ready;
    logic [QW-1:0]               pop_data;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_AW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // take a write transaction in its access cycle; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_input_reg       <= RST_COEF_INPUT;
            coef_second_reg      <= RST_COEF_SECOND;
            coef_third_reg       <= RST_COEF_THIRD;
            resonator_gain_reg   <= RST_RESONATOR;
            words_per_sample_reg <= RST_WORDS;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_COEF_INPUT:  coef_input_reg       <= pwdata[COEF_W-1:0];
                REG_COEF_SECOND: coef_second_reg      <= pwdata[COEF_W-1:0];
                REG_COEF_THIRD:  coef_third_reg       <= pwdata[COEF_W-1:0];
                REG_RESONATOR:   resonator_gain_reg   <= pwdata[COEF_W-1:0];
                REG_WORDS:       words_per_sample_reg <= pwdata[WPS_W-1:0];
                default:         ;
            endcase
        end
    end

    // read back the addressed register; holes read as zero
    always_comb
    begin
        case (reg_idx)
            REG_COEF_INPUT:  prdata = APB_DW'(coef_input_reg);
            REG_COEF_SECOND: prdata = APB_DW'(coef_second_reg);
            REG_COEF_THIRD:  prdata = APB_DW'(coef_third_reg);
            REG_RESONATOR:   prdata = APB_DW'(resonator_gain_reg);
            REG_WORDS:       prdata = APB_DW'(words_per_sample_reg);
            default:         prdata = '0;
        endcase
    end

    assign coefs.k1 = coef_input_reg;
    assign coefs.k2 = coef_second_reg;
    assign coefs.k3 = coef_third_reg;
    assign coefs.g  = resonator_gain_reg;

    // scale the sample and fix the word count at accept time
    sdm_front #(
        .MAX_WORDS (MAX_WORDS),
        .FRAC_BITS (FRAC_BITS),
        .WCNT_W    (WCNT_W)
    ) u_front (
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .words_per_sample (words_per_sample_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_u           (push_u),
        .push_words       (push_words)
    );

    // let the front keep taking samples while the loop is busy
    sdm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_words, push_u}),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // modulator loop with its own output register toward the word stream
    sdm_loop #(
        .MAX_WORDS (MAX_WORDS),
        .FRAC_BITS (FRAC_BITS),
        .ACC_WIDTH (ACC_WIDTH),
        .WCNT_W    (WCNT_W)
    ) u_loop (
        .clk       (clk),
        .rst_n     (rst_n),
        .coefs     (coefs),
        .in_valid  (pop_valid),
        .in_ready  (pop_ready),
        .in_u      ($signed(pop_data[FRAC_BITS-1:0])),
        .in_words  (pop_data[QW-1:FRAC_BITS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_last  (m_tlast),
        .out_sat   (m_tuser)
    );

endmodule

// ===== src/sdm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sigma-delta modulator, bound to the top level.
// Depends on sdm_pkg and third_order_sigma_delta_modulator.
module sdm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sdm_pkg::WORD_BITS-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser,
    input logic                          psel,
    input logic                          penable,
    input logic                          pready
);
    import sdm_pkg::*;

    logic [3:0] pending_reg;
    logic       in_take, frame_done;

    assign in_take    = s_tvalid && s_tready;
    assign frame_done = m_tvalid && m_tready && m_tlast;

    // samples accepted whose last word has not left yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 4'd0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(in_take) - 4'(frame_done);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_no_orphan_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("output word without an accepted sample");

    a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> pending_reg != 4'd0)
        else $error("input stalled with no work outstanding");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("configuration transaction not completed in its access cycle");

endmodule

bind third_order_sigma_delta_modulator sdm_checker u_sdm_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the third-order sigma-delta modulator: PCM samples in,
// PDM words out, checked word by word against a bit-accurate predictor.
// Depends on sdm_pkg and third_order_sigma_delta_modulator.
module tb;
    import sdm_pkg::*;

    localparam int     FRAC     = FRAC_BITS_DEF;
    localparam int     ACC_W    = ACC_WIDTH_DEF;
    localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO   = -(longint'(1) <<< (ACC_W - 1));
    localparam longint UNITY    = longint'(1) <<< FRAC;
    localparam int     NUM_REGS = 5;
    localparam int     REG_SLOTS = 1 << REG_IDX_W;
    localparam logic [15:0] PCM_MAX = 16'h7FFF;
    localparam logic [15:0] PCM_MIN = 16'h8000;
    localparam logic [31:0] COEF_FULL = 32'h001F_FFFF;

    // one PDM word as the block should deliver it
    typedef struct {
        logic [15:0] bits;
        logic        last;
        logic        clipped;
    } pdm_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;        // [15:0] pcm_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [WORD_BITS-1:0]  m_tdata;             // [15:0] pdm_word
    logic                  m_tlast;             // last_word
    logic                  m_tuser;             // [0] saturated
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // register shadow and modulator state of the predictor
    coef_t  k_input   = RST_COEF_INPUT;
    coef_t  k_second  = RST_COEF_SECOND;
    coef_t  k_third   = RST_COEF_THIRD;
    coef_t  k_res     = RST_RESONATOR;
    wps_t   word_count = RST_WORDS;
    longint acc_one   = 0;
    longint acc_two   = 0;
    longint acc_three = 0;
    longint fb_level  = 0;
    bit     word_clipped;

    pdm_result_t pending_words[$];
    int          errors = 0;
    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    logic [15:0] last_pcm = '0;

    third_order_sigma_delta_modulator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Clip an integrator update to the signed accumulator range and remember
    // that the current word saw clipping.
    function automatic longint clip_acc(input longint t);
        if (t > ACC_HI)
        begin
            word_clipped = 1'b1;
            return ACC_HI;
        end
        if (t < ACC_LO)
        begin
            word_clipped = 1'b1;
            return ACC_LO;
        end
        return t;
    endfunction

    // Coefficient times signal, floored back to the fixed-point scale.
    // Worst case is a 40-bit integrator times a 21-bit gain, which fits 64 bits.
    function automatic longint coef_product(input longint x, input coef_t k);
        return (x * longint'({1'b0, k})) >>> FRAC;
    endfunction

    // Run one PCM sample through the loop and queue the PDM words it yields.
    function automatic void modulate_sample(input logic [15:0] pcm);
        longint      u;
        int          words;
        pdm_result_t r;
        u = longint'($signed(pcm)) <<< (FRAC - 16);
        // a count of zero behaves as one, anything past the maximum is capped
        words = (word_count == 0) ? 1 :
                (word_count > MAX_WORDS_DEF) ? MAX_WORDS_DEF : int'(word_count);
        for (int w = 0; w < words; w++)
        begin
            r.bits = '0;
            word_clipped = 1'b0;
            for (int b = 0; b < WORD_BITS; b++)
            begin
                acc_one = clip_acc(acc_one + coef_product(u - fb_level * UNITY, k_input));
                // second stage uses the fresh first integrator but the old third
                acc_two = clip_acc(acc_two + acc_one - fb_level * longint'({1'b0, k_second})
                                   - coef_product(acc_three, k_res));
                acc_three = clip_acc(acc_three + acc_two - fb_level * longint'({1'b0, k_third}));
                if (acc_three > 0)
                begin
                    fb_level = 1;
                    r.bits[b] = 1'b1;
                end
                else
                begin
                    fb_level = -1;
                end
            end
            r.last = (w == words - 1);
            r.clipped = word_clipped;
            pending_words.push_back(r);
        end
    endfunction

    function automatic logic [31:0] reg_value(input reg_idx_t idx);
        case (idx)
            REG_COEF_INPUT:  return 32'(k_input);
            REG_COEF_SECOND: return 32'(k_second);
            REG_COEF_THIRD:  return 32'(k_third);
            REG_RESONATOR:   return 32'(k_res);
            REG_WORDS:       return 32'(word_count);
            default:         return '0;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // One APB transfer: setup phase, then access phase until pready.
    task automatic apb_access(input logic write_op, input logic [APB_AW-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_op;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register and mirror it in the predictor's shadow copy.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, {idx, 2'b00}, value, unused);
        case (idx)
            REG_COEF_INPUT:  k_input    = value[COEF_W-1:0];
            REG_COEF_SECOND: k_second   = value[COEF_W-1:0];
            REG_COEF_THIRD:  k_third    = value[COEF_W-1:0];
            REG_RESONATOR:   k_res      = value[COEF_W-1:0];
            REG_WORDS:       word_count = value[WPS_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic check_registers();
        logic [31:0] got;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b0, {reg_idx_t'(i), 2'b00}, '0, got);
            if (got !== reg_value(reg_idx_t'(i)))
                note_mismatch($sformatf("register %0d readback", i),
                              reg_value(reg_idx_t'(i)), got);
        end
    endtask

    // Offer one sample, after a random number of idle cycles, and hold it
    // until the block takes it. Predict its words at the accepting edge.
    task automatic send_sample(input logic [15:0] pcm);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pcm;
        do
            @(posedge clk);
        while (!s_tready);
        modulate_sample(pcm);
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Mix of full-range noise, quiet signal, rail values and a slowly moving
    // audio-like trace that keeps the loop in its normal operating region.
    function automatic logic [15:0] random_pcm();
        case ($urandom_range(3))
            0:       last_pcm = 16'($urandom);
            1:       last_pcm = 16'($urandom_range(0, 1023) - 512);
            2:       last_pcm = $urandom_range(1) ? PCM_MAX : PCM_MIN;
            default: last_pcm = last_pcm + 16'($urandom_range(0, 2047) - 1024);
        endcase
        return last_pcm;
    endfunction

    // Rail samples, zero, one LSB either way and alternating bit patterns.
    task automatic test_sample_extremes();
        logic [15:0] samples[8];
        samples = '{PCM_MAX, PCM_MIN, 16'h0000, 16'h0001, 16'hFFFF,
                    16'h5555, 16'hAAAA, PCM_MAX};
        foreach (samples[i])
            send_sample(samples[i]);
        drain();
    endtask

    // Word count at zero, at the maximum and beyond it (clamped to the maximum).
    task automatic test_word_count_limits();
        logic [3:0] counts[5];
        counts = '{4'd0, 4'd15, 4'd13, 4'd12, 4'd1};
        foreach (counts[i])
        begin
            write_reg(REG_WORDS, 32'(counts[i]));
            send_sample(16'($urandom));
            drain();
        end
    endtask

    // All gains zero, all gains full scale, and a runaway loop with only the
    // input gain set, which drives the integrators into clipping.
    task automatic test_coef_extremes();
        logic [31:0] sets[3][4];
        sets = '{'{32'd0, 32'd0, 32'd0, 32'd0},
                 '{COEF_FULL, COEF_FULL, COEF_FULL, COEF_FULL},
                 '{COEF_FULL, 32'd0, 32'd0, 32'd0}};
        write_reg(REG_WORDS, 32'd1);
        foreach (sets[s])
        begin
            write_reg(REG_COEF_INPUT,  sets[s][0]);
            write_reg(REG_COEF_SECOND, sets[s][1]);
            write_reg(REG_COEF_THIRD,  sets[s][2]);
            write_reg(REG_RESONATOR,   sets[s][3]);
            send_sample(PCM_MAX);
            send_sample(PCM_MIN);
            send_sample(16'($urandom));
            drain();
        end
    endtask

    // Random values with junk in the upper bits, then writes to the unused
    // slots of the map, which must leave every register alone.
    task automatic test_register_map();
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(reg_idx_t'(i), $urandom);
        check_registers();
        for (int i = NUM_REGS; i < REG_SLOTS; i++)
            write_reg(reg_idx_t'(i), $urandom);
        check_registers();
    endtask

    // One phase of random traffic under a fresh configuration. Narrow phases
    // keep the gains near their defaults; wide phases take any 32-bit value.
    task automatic test_random_phase(input bit wide, input int idle_pct,
                                     input int stall, input int items);
        if (wide)
        begin
            write_reg(REG_COEF_INPUT,  $urandom);
            write_reg(REG_COEF_SECOND, $urandom);
            write_reg(REG_COEF_THIRD,  $urandom);
            write_reg(REG_RESONATOR,   $urandom);
            write_reg(REG_WORDS,       $urandom_range(0, 15));
        end
        else
        begin
            write_reg(REG_COEF_INPUT,  RST_COEF_INPUT  + $urandom_range(0, 16383) - 8192);
            write_reg(REG_COEF_SECOND, RST_COEF_SECOND + $urandom_range(0, 32767) - 16384);
            write_reg(REG_COEF_THIRD,  RST_COEF_THIRD  + $urandom_range(0, 65535) - 32768);
            write_reg(REG_RESONATOR,   $urandom_range(0, 2 * RST_RESONATOR));
            write_reg(REG_WORDS,       $urandom_range(1, 4));
        end
        check_registers();
        sender_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (items)
            send_sample(random_pcm());
        drain();
        sender_idle_pct = 0;
        stall_pct = 0;
    endtask

    // Receiver side: stall at random per cycle, changing on the falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // Compare each accepted word with the oldest prediction.
    always @(posedge clk)
    begin : check_words
        pdm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                note_mismatch("unexpected PDM word", '0, 32'(m_tdata));
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_tdata !== want.bits)
                    note_mismatch("pdm_word", 32'(want.bits), 32'(m_tdata));
                if (m_tlast !== want.last)
                    note_mismatch("last_word", 32'(want.last), 32'(m_tlast));
                if (m_tuser !== want.clipped)
                    note_mismatch("saturated", 32'(want.clipped), 32'(m_tuser));
            end
        end
    end

    // Main sequence: reset once, directed checks, then random phases that
    // cycle through the idling modes (none, sender, receiver, both lightly).
    initial
    begin
        int idle_modes[4][2];
        idle_modes = '{'{0, 0}, '{63, 0}, '{0, 63}, '{10, 10}};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_registers();
        test_sample_extremes();
        test_word_count_limits();
        test_coef_extremes();
        test_register_map();
        for (int p = 0; p < 8; p++)
            test_random_phase(p >= 4, idle_modes[p % 4][0], idle_modes[p % 4][1], 60);

        // nothing more is predicted; give the block time to emit stray words
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/sdm_pkg.sv
src/sdm_front.sv
src/sdm_queue.sv
src/sdm_loop.sv
src/third_order_sigma_delta_modulator.sv
src/sdm_checker.sv
bench/tb.sv
